// ===== hdl/atpd_pkg.sv =====
// Shared constants, types and the digit pair decode function for the ASCII time packet deframer.
// No dependencies; imported by the top level and by the port checker.
package atpd_pkg;

    localparam int PACKET_BYTES = 15;
    localparam int IDX_W        = $clog2(PACKET_BYTES);
    localparam int CNT_W        = $clog2(PACKET_BYTES + 1);

    localparam logic [7:0] START_BYTE = 8'h40;
    localparam logic [7:0] END_BYTE   = 8'h0A;
    localparam logic [7:0] BAD_MARK   = 8'h0D;
    localparam logic [7:0] GOOD_MARK  = 8'h32;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;

    // Capture phase codes.
    localparam logic [1:0] PHASE_IDLE  = 2'd0;
    localparam logic [1:0] PHASE_CAPT  = 2'd1;
    localparam logic [1:0] PHASE_ENDED = 2'd2;

    localparam int DATA_W = 56;

    typedef logic [7:0] byte_t;

    // (t - '0') * 10 + (u - '0'), modulo 256. The digit offsets fold into one constant:
    // '0' * 11 = 528, which is 16 modulo 256.
    function automatic byte_t decode_pair(input byte_t tens, input byte_t units);
        byte_t times_ten;
        times_ten = (tens << 3) + (tens << 1);
        return times_ten + units - ((DIGIT_ZERO << 3) + (DIGIT_ZERO << 1) + DIGIT_ZERO);
    endfunction

endpackage

// ===== hdl/ascii_time_packet_deframer.sv =====
// Top level of the ASCII time packet deframer: byte capture, field decode and output buffering.
// Depends on atpd_pkg for constants, phase codes and the digit pair decode.
//
// Usage:
//   Received serial bytes enter on the s_axis channel, one byte per transfer. A byte 0x40
//   starts a packet; up to 15 bytes starting with it are kept in a byte store, and a byte
//   0x0A ends the capture after being stored itself if room remained. Every input transfer
//   produces exactly one output transfer on m_axis carrying hour, minute, second, year,
//   month and day, each decoded from a pair of ASCII digits in the store, the receive
//   indicator level and, in tuser, the sticky time-valid flag taken from store byte 1.
//   The single register reminder_enable is to be written through cfg_we / cfg_wdata only
//   while the block is idle; the block itself does not enforce this. When set, the indicator
//   drops to 0 at packet start and returns to 1 at packet end.
//   The result of an accepted byte is registered in the output register, or in the skid
//   register while m_axis stalls. Throughput is one byte per cycle while s_axis_tready is
//   high; all decode logic sits between the accepted byte and the result register.
//   Reset clears the capture state, empties the store to zeros, clears the valid flag,
//   sets the indicator inactive (1) and empties the output stage.
//   When the receiver stalls, the output register holds its result and one more result
//   goes into a skid register; s_axis_tready drops only while that skid register is full.
module ascii_time_packet_deframer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,          // reminder_enable
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,       // rx_byte
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // hour_value, minute_value, second_value, year_value, month_value, day_value,
    // receive_led_level, then zero fill
    output logic [atpd_pkg::DATA_W-1:0]  m_axis_tdata,
    output logic                         m_axis_tuser        // time_valid
);

    import atpd_pkg::*;

    // Configuration and capture state.
    logic                 reminder_reg;
    logic [1:0]           phase_reg, phase_next;
    logic [CNT_W-1:0]     remain_reg, remain_next;
    byte_t                store_reg [PACKET_BYTES];
    byte_t                store_next [PACKET_BYTES];
    logic                 valid_reg, valid_next;
    logic                 led_reg, led_next;

    // Output register and skid register.
    logic                 out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]    out_data_reg, out_data_next;
    logic                 out_user_reg, out_user_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic [DATA_W-1:0]    skid_data_reg, skid_data_next;
    logic                 skid_user_reg, skid_user_next;

    logic                 in_xfer;
    byte_t                rx;
    logic [1:0]           phase_start;
    logic [CNT_W-1:0]     remain_start;
    logic                 do_store;
    logic [IDX_W-1:0]     wr_idx;
    logic [CNT_W-1:0]     wr_pos;
    logic [DATA_W-1:0]    res_data;

    assign s_axis_tready = !skid_valid_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign rx            = s_axis_tdata;

    // Capture: a start byte opens the packet first, then the byte is stored if there is
    // room, and finally an end byte closes the packet.
    always_comb
    begin
        phase_start  = phase_reg;
        remain_start = remain_reg;
        led_next     = led_reg;
        if (rx == START_BYTE)
        begin
            phase_start  = PHASE_CAPT;
            remain_start = CNT_W'(PACKET_BYTES);
            if (reminder_reg)
            begin
                led_next = 1'b0;
            end
        end

        do_store = (phase_start == PHASE_CAPT) && (remain_start != '0)
                   && (remain_start <= CNT_W'(PACKET_BYTES));
        wr_pos   = CNT_W'(PACKET_BYTES) - remain_start;
        wr_idx   = wr_pos[IDX_W-1:0];

        phase_next  = phase_start;
        remain_next = do_store ? remain_start - 1'b1 : remain_start;
        if (rx == END_BYTE)
        begin
            phase_next  = PHASE_ENDED;
            remain_next = '0;
            if (reminder_reg)
            begin
                led_next = 1'b1;
            end
        end

        for (int i = 0; i < PACKET_BYTES; i++)
        begin
            store_next[i] = (do_store && wr_idx == IDX_W'(i)) ? rx : store_reg[i];
        end

        // Sticky valid flag follows store byte 1 after this byte has been stored.
        valid_next = valid_reg;
        if (store_next[1] == BAD_MARK)
        begin
            valid_next = 1'b0;
        end
        else if (store_next[1] == GOOD_MARK)
        begin
            valid_next = 1'b1;
        end

        res_data = {7'd0,
                    led_next,
                    decode_pair(store_next[7],  store_next[8]),
                    decode_pair(store_next[5],  store_next[6]),
                    decode_pair(store_next[3],  store_next[4]),
                    decode_pair(store_next[13], store_next[14]),
                    decode_pair(store_next[11], store_next[12]),
                    decode_pair(store_next[9],  store_next[10])};
    end

    // Output stage: the output register is refilled from the skid register first, then
    // from a new result; a new result lands in the skid register while the output stalls.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_user_next  = skid_user_reg;
        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                out_user_next   = skid_user_reg;
                skid_valid_next = 1'b0;
            end
            else if (in_xfer)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res_data;
                out_user_next  = valid_next;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_xfer)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
            skid_user_next  = valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reminder_reg   <= 1'b0;
            phase_reg      <= PHASE_IDLE;
            remain_reg     <= '0;
            valid_reg      <= 1'b0;
            led_reg        <= 1'b1;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            for (int i = 0; i < PACKET_BYTES; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                reminder_reg <= cfg_wdata;
            end
            if (in_xfer)
            begin
                phase_reg  <= phase_next;
                remain_reg <= remain_next;
                valid_reg  <= valid_next;
                led_reg    <= led_next;
                for (int i = 0; i < PACKET_BYTES; i++)
                begin
                    store_reg[i] <= store_next[i];
                end
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
        skid_data_reg <= skid_data_next;
        skid_user_reg <= skid_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

// ===== hdl/atpd_checker.sv =====
// Port-level checker for the ASCII time packet deframer, bound to the top level.
// Depends on atpd_pkg for the output data width.
module atpd_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [atpd_pkg::DATA_W-1:0]  m_axis_tdata,
    input  logic                         m_axis_tuser
);

    import atpd_pkg::*;

    // After every accepted byte, m_axis_tvalid is high in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("no result after an accepted byte");

    // A result never appears without a byte having been accepted.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result appeared without an accepted byte");

    // Input backpressure only happens while results are pending at the output.
    a_ready_low_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending result");

    // A stalled result holds its payload.
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind ascii_time_packet_deframer atpd_checker u_atpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
